// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mmp_pkg.sv
// ----------------------------------------------------------------------------
// mmp_pkg
// Types, constants and helper functions for the MIDI message parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mmp_pkg;

    localparam int BYTE_W     = 8;
    localparam int DATA_W     = 7;
    localparam int NOTE_COUNT = 128;
    localparam int NOTE_IDX_W = $clog2(NOTE_COUNT);
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Result kinds
    localparam logic KIND_MESSAGE = 1'b0;
    localparam logic KIND_STRAY   = 1'b1;

    // Register indexes (paddr[2])
    localparam logic REG_NOTE_ON  = 1'b0;
    localparam logic REG_NOTE_OFF = 1'b1;

    // Register reset values
    localparam logic [BYTE_W-1:0] NOTE_ON_RESET  = 8'h90;
    localparam logic [BYTE_W-1:0] NOTE_OFF_RESET = 8'h80;

    // Status upper nibbles
    localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
    localparam logic [3:0] NIB_POLY_AT   = 4'hA;
    localparam logic [3:0] NIB_CTRL      = 4'hB;
    localparam logic [3:0] NIB_PROGRAM   = 4'hC;
    localparam logic [3:0] NIB_CHAN_AT   = 4'hD;
    localparam logic [3:0] NIB_PITCH     = 4'hE;

    typedef logic [1:0] count_t;

    typedef struct packed {
        logic [BYTE_W-1:0] note_on_status;
        logic [BYTE_W-1:0] note_off_status;
    } mmp_cfg_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] status_value;
        logic [DATA_W-1:0] first_data;
        logic [DATA_W-1:0] second_data;
        logic              note_held;
    } mmp_result_t;

    // Number of data bytes that follow a status byte
    function automatic count_t data_count(input logic [BYTE_W-1:0] status);
        count_t cnt;
        unique case (status[7:4])
            NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_AT, NIB_CTRL, NIB_PITCH: cnt = 2'd2;
            NIB_PROGRAM, NIB_CHAN_AT:                                  cnt = 2'd1;
            default:                                                   cnt = 2'd0;
        endcase
        return cnt;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mmp_if.sv
// ----------------------------------------------------------------------------
// mmp_if
// Valid/ready channel interfaces for MIDI bytes and parsed messages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mmp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] midi_byte;

    modport source (output valid, output midi_byte, input ready);
    modport sink   (input valid, input midi_byte, output ready);
endinterface

interface mmp_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] status_value;
    logic [6:0] first_data;
    logic [6:0] second_data;
    logic       note_held;

    modport source (output valid, output kind, output status_value, output first_data,
                    output second_data, output note_held, input ready);
    modport sink   (input valid, input kind, input status_value, input first_data,
                    input second_data, input note_held, output ready);
endinterface

`default_nettype wire

// File: rtl/mmp_cfg.sv
// ----------------------------------------------------------------------------
// mmp_cfg
// APB register file holding the note-on and note-off status values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mmp_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mmp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mmp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mmp_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output mmp_pkg::mmp_cfg_t              cfg
);
    import mmp_pkg::*;

    logic [BYTE_W-1:0] note_on_reg;
    logic [BYTE_W-1:0] note_off_reg;
    logic              wr_en;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note_on_reg  <= NOTE_ON_RESET;
            note_off_reg <= NOTE_OFF_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_NOTE_ON:  note_on_reg  <= pwdata[BYTE_W-1:0];
                REG_NOTE_OFF: note_off_reg <= pwdata[BYTE_W-1:0];
                default:      ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            REG_NOTE_ON:  prdata[BYTE_W-1:0] = note_on_reg;
            REG_NOTE_OFF: prdata[BYTE_W-1:0] = note_off_reg;
            default:      prdata = '0;
        endcase
    end

    assign cfg.note_on_status  = note_on_reg;
    assign cfg.note_off_status = note_off_reg;

endmodule

`default_nettype wire

// File: rtl/mmp_parse.sv
// ----------------------------------------------------------------------------
// mmp_parse
// Input byte register, parse state and held-note map; builds one result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mmp_parse (
    input  logic                  clk,
    input  logic                  rst_n,
    mmp_in_if.sink                midi_in,
    input  mmp_pkg::mmp_cfg_t     cfg,
    input  logic                  out_space,
    output logic                  res_valid,
    output mmp_pkg::mmp_result_t  res
);
    import mmp_pkg::*;

    // input stage
    logic                  byte_valid_reg;
    logic [BYTE_W-1:0]     byte_reg;
    logic                  byte_valid_next;
    // parse state
    logic [BYTE_W-1:0]     latched_reg, latched_next;
    count_t                remain_reg, remain_next;
    logic [DATA_W-1:0]     held_data_reg, held_data_next;
    logic [NOTE_COUNT-1:0] held_map_reg, held_map_next;

    logic                  has_result;
    logic                  advance;
    logic                  two_data;
    logic                  on_match;
    logic                  off_match;
    logic [DATA_W-1:0]     data_bits;
    logic [DATA_W-1:0]     first;
    logic [NOTE_IDX_W-1:0] first_idx;
    mmp_result_t           res_c;

    // stage moves on unless a result is blocked by a full output register
    assign advance         = byte_valid_reg && (!has_result || out_space);
    assign midi_in.ready   = !byte_valid_reg || advance;
    assign byte_valid_next = (midi_in.valid && midi_in.ready) ? 1'b1
                           : (advance ? 1'b0 : byte_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_valid_reg <= 1'b0;
        else
            byte_valid_reg <= byte_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (midi_in.valid && midi_in.ready)
            byte_reg <= midi_in.midi_byte;
    end

    assign data_bits = byte_reg[DATA_W-1:0];
    assign two_data  = (data_count(latched_reg) == 2'd2);
    assign first     = two_data ? held_data_reg : data_bits;
    assign first_idx = first[NOTE_IDX_W-1:0];
    assign on_match  = (latched_reg == cfg.note_on_status);
    assign off_match = (latched_reg == cfg.note_off_status);

    // per-byte decision
    always_comb
    begin
        latched_next   = latched_reg;
        remain_next    = remain_reg;
        held_data_next = held_data_reg;
        held_map_next  = held_map_reg;
        has_result     = 1'b0;
        res_c          = '0;
        priority if (byte_reg[BYTE_W-1])
        begin
            // status byte: latch and restart collection
            latched_next   = byte_reg;
            remain_next    = data_count(byte_reg);
            held_data_next = '0;
        end
        else if (remain_reg == 2'd0)
        begin
            // stray data byte
            has_result         = 1'b1;
            res_c.kind         = KIND_STRAY;
            res_c.status_value = latched_reg;
            res_c.first_data   = data_bits;
            res_c.second_data  = '0;
            res_c.note_held    = held_map_reg[data_bits[NOTE_IDX_W-1:0]];
            latched_next       = '0;
            remain_next        = 2'd0;
            held_data_next     = '0;
        end
        else if (remain_reg >= 2'd2 && two_data)
        begin
            // first of two data bytes
            held_data_next = data_bits;
            remain_next    = 2'd1;
        end
        else
        begin
            // last data byte: complete message
            has_result         = 1'b1;
            res_c.kind         = KIND_MESSAGE;
            res_c.status_value = latched_reg;
            res_c.first_data   = first;
            res_c.second_data  = two_data ? data_bits : '0;
            priority if (on_match)
            begin
                held_map_next[first_idx] = 1'b1;
                res_c.note_held          = 1'b1;
            end
            else if (off_match)
            begin
                held_map_next[first_idx] = 1'b0;
                res_c.note_held          = 1'b0;
            end
            else
                res_c.note_held = held_map_reg[first_idx];
            latched_next   = '0;
            remain_next    = 2'd0;
            held_data_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg   <= '0;
            remain_reg    <= 2'd0;
            held_data_reg <= '0;
            held_map_reg  <= '0;
        end
        else if (advance)
        begin
            latched_reg   <= latched_next;
            remain_reg    <= remain_next;
            held_data_reg <= held_data_next;
            held_map_reg  <= held_map_next;
        end
    end

    assign res_valid = byte_valid_reg && has_result;
    assign res       = res_c;

    // checks
    `ASSERT_NEXT(a_clear_after_result, advance && has_result,
        latched_reg == '0 && remain_reg == 2'd0 && held_data_reg == '0,
        "parse state not cleared after a result")
    `ASSERT_ALWAYS(a_two_pending_needs_two, remain_reg != 2'd2 || two_data,
        "two bytes pending for a status that takes fewer")
    `ASSERT_NEXT(a_note_on_sets, advance && has_result && res_c.kind == KIND_MESSAGE && on_match,
        held_map_reg[$past(first_idx)] == 1'b1, "note-on did not set the held bit")
    `ASSERT_ALWAYS(a_stall_only_on_result, !byte_valid_reg || advance || (has_result && !out_space),
        "input stage stalled without a blocked result")

endmodule

`default_nettype wire

// File: rtl/mmp_out.sv
// ----------------------------------------------------------------------------
// mmp_out
// Output register for parsed messages; frees the input side while a result
// waits to be taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mmp_out (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    input  mmp_pkg::mmp_result_t res,
    output logic                 out_space,
    mmp_out_if.source            msg_out
);
    import mmp_pkg::*;

    logic        out_valid_reg, out_valid_next;
    mmp_result_t res_reg;
    logic        load;

    assign out_space      = !out_valid_reg || msg_out.ready;
    assign load           = res_valid && out_space;
    assign out_valid_next = load ? 1'b1 : (msg_out.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign msg_out.valid        = out_valid_reg;
    assign msg_out.kind         = res_reg.kind;
    assign msg_out.status_value = res_reg.status_value;
    assign msg_out.first_data   = res_reg.first_data;
    assign msg_out.second_data  = res_reg.second_data;
    assign msg_out.note_held    = res_reg.note_held;

endmodule

`default_nettype wire

// File: rtl/midi_message_parser_core.sv
// An accepted byte is held in the input register and decided from there; its
// result is registered in the output register, where the sink takes it.
// Throughput: one byte per cycle; the input register stalls only while its byte
// has a result and the output register is full with the sink not ready.
// Reset: clears parse state, output valid and the 128-bit held-note map at
// once; note-on/off registers return to 0x90/0x80.
// ----------------------------------------------------------------------------
// midi_message_parser_core
// MIDI channel message parser with held-note map and APB configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module midi_message_parser_core (
    input  logic                           clk,
    input  logic                           rst_n,
    mmp_in_if.sink                         midi_in,
    mmp_out_if.source                      msg_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mmp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mmp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mmp_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import mmp_pkg::*;

    mmp_cfg_t    cfg;
    mmp_result_t res;
    logic        res_valid;
    logic        out_space;

    mmp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mmp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .midi_in   (midi_in),
        .cfg       (cfg),
        .out_space (out_space),
        .res_valid (res_valid),
        .res       (res)
    );

    mmp_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_space (out_space),
        .msg_out   (msg_out)
    );

endmodule

`default_nettype wire
